>>> rtl/dn2d_pkg.sv
package dn2d_pkg;

    localparam int DAY_W   = 22;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int MDAY_W  = 5;
    localparam int DOY_W   = 9;

    // Register stages of the year split.
    localparam int NSTAGE = 7;

    // Days in the 400, 100, 4 and 1 year cycles of the calendar.
    localparam int CYC400_DAYS = 146097;
    localparam int CYC100_DAYS = 36524;
    localparam int CYC4_DAYS   = 1461;
    localparam int CYC1_DAYS   = 365;

    // Reciprocal multipliers; the estimated quotient is low by at most one.
    localparam int CYC400_SHIFT = 24;
    localparam int CYC400_RECIP = (1 << CYC400_SHIFT) / CYC400_DAYS;
    localparam int CYC4_SHIFT   = 20;
    localparam int CYC4_RECIP   = (1 << CYC4_SHIFT) / CYC4_DAYS;

    localparam int CYC4_PER_CENTURY = 24;
    localparam int LAST_CENTURY     = 3;
    localparam int LAST_YEAR_IN_CYC4 = 3;

    typedef struct packed {
        logic [DOY_W-1:0]  doy;
        logic              leap;
        logic [YEAR_W-1:0] year;
    } dn2d_ydate_t;

    // Zero-based day of the year on which a month starts.
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mon,
                                                     input logic leap);
        logic [DOY_W-1:0] base;
        case (mon)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && mon >= 4'd3)
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

>>> rtl/dn2d_year.sv
module dn2d_year
    import dn2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               day_valid,
    output logic               day_ready,
    input  logic [DAY_W-1:0]   day_number,
    output logic               ydate_valid,
    input  logic               ydate_ready,
    output dn2d_ydate_t        ydate
);

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE:0]   en;

    logic [21:0] d_a_reg;
    logic [21:0] d_a_next;

    logic [21:0] d_b_reg;
    logic [4:0]  q400_b_reg;
    logic [28:0] prod400;
    logic [4:0]  q400_b_next;

    logic [4:0]  q400_c_reg;
    logic [17:0] r400_c_reg;
    logic [21:0] sub400;
    logic [18:0] r400_est;
    logic        fix400;
    logic [4:0]  q400_c_next;
    logic [17:0] r400_c_next;

    logic [4:0]  q400_d_reg;
    logic [1:0]  q100_d_reg;
    logic [15:0] r100_d_reg;
    logic [1:0]  q100_d_next;
    logic [15:0] r100_d_next;

    logic [4:0]  q400_e_reg;
    logic [1:0]  q100_e_reg;
    logic [15:0] r100_e_reg;
    logic [4:0]  q4_e_reg;
    logic [25:0] prod4;
    logic [4:0]  q4_e_next;

    logic [4:0]  q400_f_reg;
    logic [1:0]  q100_f_reg;
    logic [4:0]  q4_f_reg;
    logic [10:0] r4_f_reg;
    logic [15:0] sub4;
    logic [11:0] r4_est;
    logic        fix4;
    logic [4:0]  q4_f_next;
    logic [10:0] r4_f_next;

    dn2d_ydate_t ydate_reg;
    dn2d_ydate_t ydate_next;
    logic [1:0]  q1;

    always_comb
    begin
        en[NSTAGE] = ydate_ready;
        for (int i = NSTAGE - 1; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign day_ready   = en[0];
    assign ydate_valid = valid_reg[NSTAGE-1];
    assign ydate       = ydate_reg;

    // Day zero and day one both land on the first day of the epoch.
    assign d_a_next = (day_number == '0) ? '0 : day_number - 22'd1;

    assign prod400     = 29'(d_a_reg) * 29'(CYC400_RECIP);
    assign q400_b_next = 5'(prod400 >> CYC400_SHIFT);

    assign sub400      = d_b_reg - 22'(q400_b_reg * 22'(CYC400_DAYS));
    assign r400_est    = 19'(sub400);
    assign fix400      = r400_est >= 19'(CYC400_DAYS);
    assign q400_c_next = q400_b_reg + 5'(fix400);
    assign r400_c_next = fix400 ? 18'(r400_est - 19'(CYC400_DAYS)) : 18'(r400_est);

    // The last century of a cycle is one day longer, so the quotient saturates at three.
    always_comb
    begin
        if (r400_c_reg >= 18'(3 * CYC100_DAYS))
        begin
            q100_d_next = 2'd3;
        end
        else if (r400_c_reg >= 18'(2 * CYC100_DAYS))
        begin
            q100_d_next = 2'd2;
        end
        else if (r400_c_reg >= 18'(CYC100_DAYS))
        begin
            q100_d_next = 2'd1;
        end
        else
        begin
            q100_d_next = 2'd0;
        end
        r100_d_next = 16'(r400_c_reg - 18'(q100_d_next) * 18'(CYC100_DAYS));
    end

    assign prod4     = 26'(r100_d_reg) * 26'(CYC4_RECIP);
    assign q4_e_next = 5'(prod4 >> CYC4_SHIFT);

    assign sub4      = r100_e_reg - 16'(q4_e_reg * 16'(CYC4_DAYS));
    assign r4_est    = 12'(sub4);
    assign fix4      = r4_est >= 12'(CYC4_DAYS);
    assign q4_f_next = q4_e_reg + 5'(fix4);
    assign r4_f_next = fix4 ? 11'(r4_est - 12'(CYC4_DAYS)) : 11'(r4_est);

    always_comb
    begin
        if (r4_f_reg >= 11'(3 * CYC1_DAYS))
        begin
            q1 = 2'd3;
        end
        else if (r4_f_reg >= 11'(2 * CYC1_DAYS))
        begin
            q1 = 2'd2;
        end
        else if (r4_f_reg >= 11'(CYC1_DAYS))
        begin
            q1 = 2'd1;
        end
        else
        begin
            q1 = 2'd0;
        end
        ydate_next.doy  = 9'(r4_f_reg - 11'(q1) * 11'(CYC1_DAYS));
        // A leap year ends each four year block, except the short one closing a century.
        ydate_next.leap = (q1 == 2'(LAST_YEAR_IN_CYC4))
                          && (q4_f_reg != 5'(CYC4_PER_CENTURY)
                              || q100_f_reg == 2'(LAST_CENTURY));
        ydate_next.year = 14'(14'(q400_f_reg) * 14'd400 + 14'(q100_f_reg) * 14'd100
                              + 14'(q4_f_reg) * 14'd4 + 14'(q1) + 14'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= day_valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_a_reg <= d_a_next;
        end
        if (en[1])
        begin
            d_b_reg    <= d_a_reg;
            q400_b_reg <= q400_b_next;
        end
        if (en[2])
        begin
            q400_c_reg <= q400_c_next;
            r400_c_reg <= r400_c_next;
        end
        if (en[3])
        begin
            q400_d_reg <= q400_c_reg;
            q100_d_reg <= q100_d_next;
            r100_d_reg <= r100_d_next;
        end
        if (en[4])
        begin
            q400_e_reg <= q400_d_reg;
            q100_e_reg <= q100_d_reg;
            r100_e_reg <= r100_d_reg;
            q4_e_reg   <= q4_e_next;
        end
        if (en[5])
        begin
            q400_f_reg <= q400_e_reg;
            q100_f_reg <= q100_e_reg;
            q4_f_reg   <= q4_f_next;
            r4_f_reg   <= r4_f_next;
        end
        if (en[6])
        begin
            ydate_reg <= ydate_next;
        end
    end

`ifndef SYNTH
    a_r400_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> r400_c_reg < 18'(CYC400_DAYS))
        else $error("Remainder of the 400 year cycle is out of range.");

    a_r4_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[5] |-> (r4_f_reg < 11'(CYC4_DAYS) && q4_f_reg <= 5'(CYC4_PER_CENTURY)))
        else $error("Four year block split is out of range.");

    a_doy_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[6] |-> (ydate_reg.doy < 9'(CYC1_DAYS) || ydate_reg.leap))
        else $error("Day 366 given in a common year.");
`endif

endmodule

>>> rtl/dn2d_month.sv
module dn2d_month
    import dn2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ydate_valid,
    output logic               ydate_ready,
    input  dn2d_ydate_t        ydate,
    output logic               date_valid,
    input  logic               date_ready,
    output logic [MDAY_W-1:0]  day_of_month,
    output logic [MONTH_W-1:0] month_number,
    output logic [YEAR_W-1:0]  year_number
);

    logic                date_valid_reg;
    logic [MDAY_W-1:0]   mday_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [MDAY_W-1:0]   mday_next;
    logic [MONTH_W-1:0]  month_next;
    logic                load;

    assign ydate_ready = !date_valid_reg || date_ready;
    assign load        = ydate_valid && ydate_ready;

    always_comb
    begin
        month_next = 4'd1;
        for (int m = 2; m <= 12; m++)
        begin
            if (ydate.doy >= month_start(4'(m), ydate.leap))
            begin
                month_next = 4'(m);
            end
        end
        mday_next = 5'(ydate.doy - month_start(month_next, ydate.leap) + 9'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_valid_reg <= 1'b0;
        end
        else if (ydate_ready)
        begin
            date_valid_reg <= ydate_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mday_reg  <= mday_next;
            month_reg <= month_next;
            year_reg  <= ydate.year;
        end
    end

    assign date_valid   = date_valid_reg;
    assign day_of_month = mday_reg;
    assign month_number = month_reg;
    assign year_number  = year_reg;

`ifndef SYNTH
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid_reg |-> (month_reg >= 4'd1 && month_reg <= 4'd12 && mday_reg != 5'd0))
        else $error("Month or day of month is out of range.");

    a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid_reg && month_reg == 4'd2 |-> mday_reg <= 5'd29)
        else $error("February runs past its length.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid_reg && !date_ready |=> date_valid_reg && $stable(mday_reg)
            && $stable(month_reg) && $stable(year_reg))
        else $error("Date word changed while waiting.");
`endif

endmodule

>>> rtl/day_number_to_date.sv
// Converts a serial day number of the proleptic Gregorian calendar, where day 1 is
// 1 January of year 1 and day 0 gives the same date, into day of month, month and
// year. The conversion runs through an eight stage pipeline: the day count is split
// into 400 year, century, four year and single year parts with reciprocal
// multipliers and constant compares, and a last stage walks the month starts. A word
// is accepted in every cycle while date_ready stays high; when date_ready is low the
// pipeline closes its bubbles and then holds.
// Every 22-bit input is valid, giving years up to about 11484.
module day_number_to_date
    import dn2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               day_valid,
    output logic               day_ready,
    input  logic [DAY_W-1:0]   day_number,
    output logic               date_valid,
    input  logic               date_ready,
    output logic [MDAY_W-1:0]  day_of_month,
    output logic [MONTH_W-1:0] month_number,
    output logic [YEAR_W-1:0]  year_number
);

    logic        ydate_valid;
    logic        ydate_ready;
    dn2d_ydate_t ydate;

    dn2d_year u_year (
        .clk         (clk),
        .rst_n       (rst_n),
        .day_valid   (day_valid),
        .day_ready   (day_ready),
        .day_number  (day_number),
        .ydate_valid (ydate_valid),
        .ydate_ready (ydate_ready),
        .ydate       (ydate)
    );

    dn2d_month u_month (
        .clk          (clk),
        .rst_n        (rst_n),
        .ydate_valid  (ydate_valid),
        .ydate_ready  (ydate_ready),
        .ydate        (ydate),
        .date_valid   (date_valid),
        .date_ready   (date_ready),
        .day_of_month (day_of_month),
        .month_number (month_number),
        .year_number  (year_number)
    );

endmodule
